// ----- hdl/cbm_pkg.sv -----
`default_nettype none

package cbm_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC3 = 2'd2,
    KIND_MBC5 = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_KIND        = 2'd0,
    CFG_ROM_MASK    = 2'd1,
    CFG_RAM_PRESENT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_ROM_READ   = 3'd0,
    ST_RAM_READ   = 3'd1,
    ST_RAM_WRITE  = 3'd2,
    ST_RTC_READ   = 3'd3,
    ST_OPEN_BUS   = 3'd4,
    ST_REG_UPDATE = 3'd5,
    ST_IGNORED    = 3'd6,
    ST_UNMAPPED   = 3'd7
  } status_t;

  // Address windows on addr[15:13]
  localparam logic [2:0] WIN_RAM_ENABLE = 3'b000;
  localparam logic [2:0] WIN_ROM_BANK   = 3'b001;
  localparam logic [2:0] WIN_RAM_BANK   = 3'b010;
  localparam logic [2:0] WIN_MODE       = 3'b011;
  localparam logic [2:0] WIN_EXT_RAM    = 3'b101;

  localparam logic [7:0] RAM_ENABLE_CODE = 8'h0A;
  localparam logic [3:0] RTC_SEL_FIRST   = 4'h8;
  localparam logic [3:0] RTC_SEL_LAST    = 4'hC;
  localparam logic [3:0] RAM_SEL_LAST    = 4'h3;

  localparam int CFG_DATA_W = 9;
  localparam int ROM_BANK_W = 9;
  localparam int RAM_BANK_W = 4;
  localparam int ROM_ADDR_W = 23;
  localparam int RAM_ADDR_W = 17;

endpackage

`default_nettype wire

// ----- hdl/cartridge_bank_mapper.sv -----
// An input transfer's result is registered onto the out_ channel next cycle.
// Throughput: one access per cycle while out_ready is high; the result register
// frees in the same cycle it is drained, so input and output transfer together.
// Reset (rst_n, synchronous, active low): drops any pending result, sets the ROM
// bank registers to 1 and the other bank registers to 0, disables RAM, clears the
// dirty flag and returns config to no controller, ROM mask 1 and no RAM.
`default_nettype none

module cartridge_bank_mapper
  import cbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_command,
  input  wire logic [15:0]           in_address,
  input  wire logic [7:0]            in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_status,
  output logic [ROM_ADDR_W-1:0]      out_rom_address,
  output logic [RAM_ADDR_W-1:0]      out_ram_address,
  output logic [2:0]                 out_rtc_register,
  output logic [7:0]                 out_write_data,
  output logic                       out_save_request
);

  // configuration
  kind_t                 kind_r;
  logic [ROM_BANK_W-1:0] rom_mask_r;
  logic                  ram_present_r;

  // bank state
  logic [4:0]            low_bank_sel_r,  low_bank_sel_nxt;
  logic [1:0]            high_bank_sel_r, high_bank_sel_nxt;
  logic                  banking_mode_r,  banking_mode_nxt;
  logic [6:0]            rtc_rom_bank_r,  rtc_rom_bank_nxt;
  logic [3:0]            ram_rtc_sel_r,   ram_rtc_sel_nxt;
  logic [ROM_BANK_W-1:0] wide_rom_bank_r, wide_rom_bank_nxt;
  logic [RAM_BANK_W-1:0] wide_ram_bank_r, wide_ram_bank_nxt;
  logic                  ram_enabled_r,   ram_enabled_nxt;
  logic                  ram_dirty_r,     ram_dirty_nxt;

  // result register
  logic                  out_valid_r;
  status_t               status_r,  status_nxt;
  logic [ROM_ADDR_W-1:0] rom_addr_r, rom_addr_nxt;
  logic [RAM_ADDR_W-1:0] ram_addr_r, ram_addr_nxt;
  logic [2:0]            rtc_reg_r,  rtc_reg_nxt;
  logic [7:0]            wdata_r,    wdata_nxt;
  logic                  save_r,     save_nxt;

  logic                  in_xfer;
  logic [6:0]            mbc1_bank7;
  logic [ROM_BANK_W-1:0] mbc1_rom_page;
  logic [ROM_BANK_W-1:0] rom_page;
  logic [RAM_BANK_W-1:0] mbc1_ram_bank;
  logic [RAM_BANK_W-1:0] wr_ram_bank;
  logic                  enable_hit;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    mbc1_bank7    = banking_mode_r ? {2'b00, low_bank_sel_r} : {high_bank_sel_r, low_bank_sel_r};
    mbc1_rom_page = (mbc1_bank7 == 7'd0) ? ROM_BANK_W'(1)
                                         : ({2'b00, mbc1_bank7} & rom_mask_r);
    mbc1_ram_bank = banking_mode_r ? {2'b00, high_bank_sel_r} : '0;
    unique case (kind_r)
      KIND_MBC1: begin
        rom_page    = mbc1_rom_page;
        wr_ram_bank = mbc1_ram_bank;
      end
      KIND_MBC3: begin
        rom_page    = {2'b00, rtc_rom_bank_r};
        wr_ram_bank = ram_rtc_sel_r;
      end
      KIND_MBC5: begin
        rom_page    = wide_rom_bank_r & rom_mask_r;
        wr_ram_bank = wide_ram_bank_r;
      end
      default: begin
        rom_page    = '0;
        wr_ram_bank = '0;
      end
    endcase
    enable_hit = (kind_r == KIND_MBC5) ? (in_data == RAM_ENABLE_CODE)
                                       : (in_data[3:0] == RAM_ENABLE_CODE[3:0]);
  end

  always_comb begin
    low_bank_sel_nxt  = low_bank_sel_r;
    high_bank_sel_nxt = high_bank_sel_r;
    banking_mode_nxt  = banking_mode_r;
    rtc_rom_bank_nxt  = rtc_rom_bank_r;
    ram_rtc_sel_nxt   = ram_rtc_sel_r;
    wide_rom_bank_nxt = wide_rom_bank_r;
    wide_ram_bank_nxt = wide_ram_bank_r;
    ram_enabled_nxt   = ram_enabled_r;
    ram_dirty_nxt     = ram_dirty_r;
    status_nxt        = ST_UNMAPPED;
    rom_addr_nxt      = '0;
    ram_addr_nxt      = '0;
    rtc_reg_nxt       = '0;
    wdata_nxt         = '0;
    save_nxt          = 1'b0;

    if (!in_command) begin
      if (in_address[15:14] == 2'b00) begin
        status_nxt   = ST_ROM_READ;
        rom_addr_nxt = {7'd0, in_address};
      end else if (!in_address[15]) begin
        status_nxt   = ST_ROM_READ;
        rom_addr_nxt = (kind_r == KIND_NONE) ? {7'd0, in_address}
                                             : {rom_page, in_address[13:0]};
      end else if (in_address[15:13] == WIN_EXT_RAM && kind_r != KIND_NONE) begin
        if (!ram_enabled_r) begin
          status_nxt = ST_OPEN_BUS;
        end else if (kind_r == KIND_MBC3) begin
          if (ram_rtc_sel_r <= RAM_SEL_LAST) begin
            status_nxt   = ST_RAM_READ;
            ram_addr_nxt = {ram_rtc_sel_r, in_address[12:0]};
          end else if (ram_rtc_sel_r >= RTC_SEL_FIRST && ram_rtc_sel_r <= RTC_SEL_LAST) begin
            status_nxt  = ST_RTC_READ;
            rtc_reg_nxt = ram_rtc_sel_r[2:0];
          end else begin
            status_nxt = ST_OPEN_BUS;
          end
        end else begin
          status_nxt   = ST_RAM_READ;
          ram_addr_nxt = {wr_ram_bank, in_address[12:0]};
        end
      end
    end else if (kind_r == KIND_NONE) begin
      status_nxt = ST_IGNORED;
    end else begin
      unique case (in_address[15:13])
        WIN_RAM_ENABLE: begin
          status_nxt      = ST_REG_UPDATE;
          ram_enabled_nxt = enable_hit;
          if (enable_hit) begin
            ram_dirty_nxt = 1'b0;
          end else begin
            save_nxt = ram_present_r && ram_dirty_r;
          end
        end
        WIN_ROM_BANK: begin
          status_nxt = ST_REG_UPDATE;
          unique case (kind_r)
            KIND_MBC1: low_bank_sel_nxt = in_data[4:0];
            KIND_MBC3: rtc_rom_bank_nxt = (in_data[6:0] == 7'd0) ? 7'd1 : in_data[6:0];
            KIND_MBC5: begin
              if (!in_address[12]) begin
                wide_rom_bank_nxt = {wide_rom_bank_r[8], in_data};
              end else begin
                wide_rom_bank_nxt = {in_data[0], wide_rom_bank_r[7:0]};
              end
            end
            default: ;
          endcase
        end
        WIN_RAM_BANK: begin
          status_nxt = ST_REG_UPDATE;
          unique case (kind_r)
            KIND_MBC1: high_bank_sel_nxt = in_data[1:0];
            KIND_MBC3: ram_rtc_sel_nxt   = in_data[3:0];
            KIND_MBC5: wide_ram_bank_nxt = in_data[3:0];
            default: ;
          endcase
        end
        WIN_MODE: begin
          if (kind_r == KIND_MBC1) begin
            status_nxt       = ST_REG_UPDATE;
            banking_mode_nxt = in_data[0];
          end else begin
            status_nxt = ST_IGNORED;
          end
        end
        WIN_EXT_RAM: begin
          if (!ram_enabled_r || (kind_r == KIND_MBC3 && ram_rtc_sel_r > RAM_SEL_LAST)) begin
            status_nxt = ST_IGNORED;
          end else begin
            status_nxt    = ST_RAM_WRITE;
            ram_addr_nxt  = {wr_ram_bank, in_address[12:0]};
            wdata_nxt     = in_data;
            ram_dirty_nxt = 1'b1;
          end
        end
        default: status_nxt = ST_UNMAPPED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r        <= KIND_NONE;
      rom_mask_r    <= ROM_BANK_W'(1);
      ram_present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_KIND:        kind_r        <= kind_t'(cfg_data[1:0]);
        CFG_ROM_MASK:    rom_mask_r    <= cfg_data[ROM_BANK_W-1:0];
        CFG_RAM_PRESENT: ram_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bank_sel_r  <= 5'd1;
      high_bank_sel_r <= '0;
      banking_mode_r  <= 1'b0;
      rtc_rom_bank_r  <= 7'd1;
      ram_rtc_sel_r   <= '0;
      wide_rom_bank_r <= ROM_BANK_W'(1);
      wide_ram_bank_r <= '0;
      ram_enabled_r   <= 1'b0;
      ram_dirty_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        low_bank_sel_r  <= low_bank_sel_nxt;
        high_bank_sel_r <= high_bank_sel_nxt;
        banking_mode_r  <= banking_mode_nxt;
        rtc_rom_bank_r  <= rtc_rom_bank_nxt;
        ram_rtc_sel_r   <= ram_rtc_sel_nxt;
        wide_rom_bank_r <= wide_rom_bank_nxt;
        wide_ram_bank_r <= wide_ram_bank_nxt;
        ram_enabled_r   <= ram_enabled_nxt;
        ram_dirty_r     <= ram_dirty_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r   <= status_nxt;
      rom_addr_r <= rom_addr_nxt;
      ram_addr_r <= ram_addr_nxt;
      rtc_reg_r  <= rtc_reg_nxt;
      wdata_r    <= wdata_nxt;
      save_r     <= save_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_rom_address  = rom_addr_r;
  assign out_ram_address  = ram_addr_r;
  assign out_rtc_register = rtc_reg_r;
  assign out_write_data   = wdata_r;
  assign out_save_request = save_r;

endmodule

`default_nettype wire

// ----- hdl/cbm_checker.sv -----
`default_nettype none

module cbm_checker
  import cbm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [2:0]            out_status,
  input wire logic [ROM_ADDR_W-1:0] out_rom_address,
  input wire logic [RAM_ADDR_W-1:0] out_ram_address,
  input wire logic [7:0]            out_write_data,
  input wire logic                  out_save_request
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_rom_address) && $stable(out_ram_address))
    else $error("result changed while stalled");

  // every input transfer shows up as a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("missing result after input transfer");

  a_save_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_save_request |-> out_status == ST_REG_UPDATE)
    else $error("save request outside a register update");

  a_wdata_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_RAM_WRITE |-> out_write_data == 8'd0)
    else $error("write data on a non RAM write");

  a_ram_addr_use: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_RAM_READ && out_status != ST_RAM_WRITE
      |-> out_ram_address == '0)
    else $error("RAM address on a non RAM access");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);

`default_nettype wire
